/* sv/tpe_pkg.sv */
// shared types and constants for the tau_p period estimator
`default_nettype none
package tpe_pkg;
    localparam int unsigned PERIOD_WIDTH = 24;
    localparam int unsigned RATE_WIDTH   = 10;
    localparam logic [31:0] TWO_PI_Q28   = 32'h6487ED51;
    localparam logic [23:0] PERIOD_MAX   = 24'hFFFFFF;
    localparam logic [0:0]  REG_SAMPLE_RATE = 1'b0;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } tpe_div_req_t;
endpackage
`default_nettype wire

/* sv/tpe_if.sv */
// valid/ready channel interface
`default_nettype none
interface tpe_if #(parameter int W = 24);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    logic         restart;
    modport source (output valid, output data, output restart, input ready);
    modport sink   (input valid, input data, input restart, output ready);
endinterface
`default_nettype wire

/* sv/tau_p_period_estimator_core.sv */
// tau_p predominant period estimator top level
// a word passes through the two decay divisions, the ratio division, the square root and the
//   period division, all divisions on the shared divider; a first-sample word goes straight
//   to the output, and no new word is taken until the last result has been taken
// reset: rst_n asynchronous active low clears rate, sums and the primed flag
`default_nettype none
module tau_p_period_estimator_core
    import tpe_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tpe_if.sink              in_ch,
    tpe_if.source            out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DECV  = 10'b0000000010,
        S_DECD  = 10'b0000000100,
        S_UPD   = 10'b0000001000,
        S_RATIO = 10'b0000010000,
        S_SQRT  = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_PDIV  = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_WAIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [RATE_WIDTH-1:0] rate_reg;
    logic primed_reg;
    logic [SAMPLE_WIDTH-1:0] prev_reg;
    logic [63:0] ve_reg, sd_reg;
    logic [63:0] sqv_reg, sqd_reg;
    logic [23:0] out_reg;
    logic        out_valid_reg;
    logic [63:0] r_reg;      // sqrt remainder
    logic [63:0] rad_reg;    // radicand shifting out
    logic [31:0] root_reg;
    logic [5:0]  step_reg;
    logic [63:0] prod_reg;
    logic        div_go;
    tpe_div_req_t dreq;
    logic        dbusy;
    logic [95:0] dquot;
    logic [63:0] drem;
    logic        cfg_wr;

    // squares of the input sample and difference; magnitudes are one bit wider than a sample
    logic signed [SAMPLE_WIDTH:0] diff_s;
    logic [SAMPLE_WIDTH:0] mag_x, mag_d;
    logic [63:0] sq_x, sq_d;
    logic signed [SAMPLE_WIDTH-1:0] xin;

    assign xin    = in_ch.data[SAMPLE_WIDTH-1:0];
    assign diff_s = {xin[SAMPLE_WIDTH-1], xin} - {prev_reg[SAMPLE_WIDTH-1], prev_reg};
    assign mag_x  = xin[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-{xin[SAMPLE_WIDTH-1], xin})
                                        : {1'b0, xin};
    assign mag_d  = diff_s[SAMPLE_WIDTH] ? (SAMPLE_WIDTH+1)'(-diff_s) : diff_s;
    assign sq_x   = 64'(mag_x) * 64'(mag_x);
    assign sq_d   = 64'(mag_d) * 64'(mag_d);

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_SAMPLE_RATE);
    assign pready = 1'b1;
    assign prdata = (paddr == REG_SAMPLE_RATE) ? 32'(rate_reg) : 32'd0;

    assign in_ch.ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
    assign out_ch.restart = 1'b0;

    always_comb
    begin
        dreq.start = div_go;
        dreq.num   = ve_reg;
        dreq.den   = sd_reg;
        case (state_reg)
            S_IDLE:  dreq.num = ve_reg;
            S_DECV:  dreq.num = sd_reg;
            S_UPD:   dreq.num = ve_reg;
            S_MUL:   dreq.num = prod_reg;
            default: dreq.num = ve_reg;
        endcase
        if (state_reg == S_RATIO || state_reg == S_UPD)
            dreq.den = sd_reg;
        else if (state_reg == S_MUL)
            dreq.den = 64'(rate_reg) << 28;
        else
            dreq.den = 64'(rate_reg);
    end

    tpe_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .busy (dbusy),
        .quot (dquot),
        .rem  (drem)
    );

    // decay amount from divider quotient (integer part is quot[95:32])
    logic [63:0] dec_q;
    assign dec_q = dquot[95:32];

    // square root trial step
    logic [63:0] trial, r_shift;
    assign r_shift = {r_reg[61:0], rad_reg[63:62]};
    assign trial   = {30'd0, root_reg, 2'b01};

    // saturating sum updates, value sum already decayed, slope sum decays here
    logic [63:0] sd_dec;
    logic [64:0] ve_sum, sd_sum;
    assign sd_dec = (rate_reg >= 10'd2) ? sd_reg - dec_q : 64'd0;
    assign ve_sum = {1'b0, ve_reg} + {1'b0, sqv_reg};
    assign sd_sum = {1'b0, sd_dec} + {1'b0, sqd_reg};

    always_comb
    begin
        state_next = state_reg;
        div_go     = 1'b0;
        case (state_reg)
            S_IDLE:  if (in_ch.valid && in_ch.ready)
                     begin
                         if (!primed_reg || in_ch.restart)
                             state_next = S_OUT;
                         else
                         begin
                             state_next = S_DECV;
                             div_go     = 1'b1;
                         end
                     end
            S_DECV:  if (!dbusy)
                     begin
                         state_next = S_DECD;
                         div_go     = 1'b1;
                     end
            S_DECD:  if (!dbusy)
                     begin
                         state_next = S_UPD;
                     end
            S_UPD:   begin
                         state_next = S_RATIO;
                         div_go     = 1'b1;
                     end
            S_RATIO: if (!dbusy)
                         state_next = S_SQRT;
            S_SQRT:  if (step_reg == 6'd0)
                         state_next = S_MUL;
            S_MUL:   begin
                         state_next = S_PDIV;
                         div_go     = 1'b1;
                     end
            S_PDIV:  if (!dbusy)
                         state_next = S_OUT;
            S_OUT:   state_next = S_WAIT;
            S_WAIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            ve_reg        <= '0;
            sd_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                rate_reg   <= pwdata[RATE_WIDTH-1:0];
                primed_reg <= 1'b0;
                ve_reg     <= '0;
                sd_reg     <= '0;
            end
            case (state_reg)
                S_IDLE:
                    if (in_ch.valid && in_ch.ready)
                    begin
                        primed_reg <= 1'b1;
                        if (!primed_reg || in_ch.restart)
                        begin
                            ve_reg <= '0;
                            sd_reg <= '0;
                        end
                    end
                S_DECV:
                    if (!dbusy)
                        ve_reg <= (rate_reg >= 10'd2) ? ve_reg - dec_q : 64'd0;
                S_DECD:
                    if (!dbusy)
                    begin
                        ve_reg <= ve_sum[64] ? '1 : ve_sum[63:0];
                        sd_reg <= sd_sum[64] ? '1 : sd_sum[63:0];
                    end
                S_UPD:
                    ;
                S_OUT:
                    out_valid_reg <= 1'b1;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    prev_reg <= xin;
                    sqv_reg  <= sq_x;
                    sqd_reg  <= sq_d;
                    out_reg  <= '0;
                end
            S_RATIO:
                if (!dbusy)
                begin
                    r_reg    <= '0;
                    rad_reg  <= dquot[63:0];
                    root_reg <= '0;
                    step_reg <= 6'd32;
                    if (rate_reg == '0 || sd_reg == '0)
                        out_reg <= '0;
                    else if (dquot[95:64] != 32'd0)
                        out_reg <= PERIOD_MAX;
                end
            S_SQRT:
                if (step_reg != 6'd0)
                begin
                    step_reg <= step_reg - 6'd1;
                    rad_reg  <= {rad_reg[61:0], 2'b00};
                    if (r_shift >= trial)
                    begin
                        r_reg    <= r_shift - trial;
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        r_reg    <= r_shift;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                end
                else
                    prod_reg <= 64'(root_reg) * 64'(TWO_PI_Q28);
            S_PDIV:
                if (!dbusy && rate_reg != '0 && sd_reg != '0 && out_reg != PERIOD_MAX)
                    out_reg <= (dquot[95:56] != 40'd0) ? PERIOD_MAX : dquot[55:32];
            default:
                ;
        endcase
    end

    logic unused_ok;
    assign unused_ok = ^drem;

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> out_ch.valid) else $error("no result");
endmodule
`default_nettype wire

/* sv/tpe_divider.sv */
// shared restoring divider, one quotient bit per cycle, 64/64 plus 32 fraction bits
`default_nettype none
module tpe_divider
    import tpe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire tpe_div_req_t req,
    output logic              busy,
    output logic [95:0]       quot,
    output logic [63:0]       rem
);
    logic [6:0]   cnt_reg, cnt_next;
    logic [95:0]  q_reg, q_next;
    logic [64:0]  r_reg, r_next;
    logic [63:0]  d_reg;
    logic [64:0]  shifted;

    always_comb
    begin
        shifted  = {r_reg[63:0], q_reg[95]};
        q_next   = {q_reg[94:0], 1'b0};
        r_next   = shifted;
        cnt_next = cnt_reg;
        if (cnt_reg != 7'd0)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (shifted >= {1'b0, d_reg})
            begin
                r_next    = shifted - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
        end
        else
        begin
            q_next = q_reg;
            r_next = r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 7'd0;
        else if (req.start)
            cnt_reg <= 7'd96;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg <= {req.num, 32'd0};
            r_reg <= 65'd0;
            d_reg <= req.den;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy = (cnt_reg != 7'd0);
    assign quot = q_reg;
    assign rem  = r_reg[63:0];
endmodule
`default_nettype wire
